// File: sv/qeyt_pkg.sv
// ----------------------------------------------------------------------------
// qeyt_pkg
// Shared types and constants of the quaternion to Euler yaw tracker.
// ----------------------------------------------------------------------------
package qeyt_pkg;

  // Input commands carried in the input tuser field.
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_HALL   = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] REG_HALL_ENABLED = 1'b0;
  localparam logic [0:0] REG_HALL_TIMEOUT = 1'b1;

  // Angle jobs of the shared CORDIC, in the order they run.
  localparam logic [1:0] JOB_ROLL  = 2'd0;
  localparam logic [1:0] JOB_YAW   = 2'd1;
  localparam logic [1:0] JOB_PITCH = 2'd2;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 152;
  localparam int MUL_PAIRS  = 10;
  localparam int STEP_W     = 5;
  localparam int CXY_W      = 40;
  localparam int CZ_W       = 34;

  // Controller to datapath commands.
  typedef struct packed {
    logic              capture;
    logic              mul_clear;
    logic              mul_en;
    logic [3:0]        mul_idx;
    logic              sqrt_start;
    logic              cord_load;
    logic              cord_step;
    logic              cord_last;
    logic [STEP_W-1:0] step_idx;
    logic [1:0]        job;
    logic              update;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sqrt_busy;
    logic out_busy;
  } sts_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_of(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/quaternion_euler_yaw_tracker_core.sv
// ----------------------------------------------------------------------------
// quaternion_euler_yaw_tracker_core
// Quaternion to roll, pitch and yaw with hall zeroing and yaw unwrapping.
// ----------------------------------------------------------------------------
// One word at a time. An orientation sample takes a pass over 10 products,
// then three CORDIC jobs of CORDIC_STEPS rotation steps each on the one
// shared CORDIC unit, then the state update and the output. The pitch square
// root runs alongside the roll and yaw jobs; the pitch job waits for it while
// it is still busy. Hall pulses and time checks go straight to the update.
// The next word is taken while a result waits in the output register.
// Angles are in units of 65536 per turn.
module quaternion_euler_yaw_tracker_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z, time_us
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  // roll_angle, pitch_angle, yaw_raw, yaw_zeroed, yaw_continuous,
  // sample_count, timeout_count, timeout_active, zero fill
  output logic [151:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import qeyt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  qeyt_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  qeyt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: sv/qeyt_ctrl.sv
// ----------------------------------------------------------------------------
// qeyt_ctrl
// Sequencer: product pass, three CORDIC jobs and the state update.
// ----------------------------------------------------------------------------
module qeyt_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,
  output qeyt_pkg::cmd_t cmd,
  input  qeyt_pkg::sts_t sts
);
  import qeyt_pkg::*;

  localparam int SC_W = $clog2(CORDIC_STEPS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_CLOAD = 5'b00100,
    S_CRUN  = 5'b01000,
    S_UPD   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [3:0]      mcnt_r, mcnt_nxt;
  logic [SC_W-1:0] scnt_r, scnt_nxt;
  logic [1:0]      job_r, job_nxt;
  logic            in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    mcnt_nxt  = mcnt_r;
    scnt_nxt  = scnt_r;
    job_nxt   = job_r;
    cmd            = '0;
    cmd.mul_idx    = mcnt_r;
    cmd.step_idx   = STEP_W'(scnt_r);
    cmd.job        = job_r;
    cmd.capture    = in_fire;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_SAMPLE) begin
            cmd.mul_clear = 1'b1;
            mcnt_nxt  = '0;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (mcnt_r == 4'(MUL_PAIRS - 1)) begin
          job_nxt   = JOB_ROLL;
          state_nxt = S_CLOAD;
        end else begin
          mcnt_nxt = mcnt_r + 4'd1;
        end
      end
      S_CLOAD: begin
        if (job_r == JOB_ROLL) cmd.sqrt_start = 1'b1;
        if (!(job_r == JOB_PITCH && sts.sqrt_busy)) begin
          cmd.cord_load = 1'b1;
          scnt_nxt  = '0;
          state_nxt = S_CRUN;
        end
      end
      S_CRUN: begin
        cmd.cord_step = 1'b1;
        if (scnt_r == SC_W'(CORDIC_STEPS - 1)) begin
          cmd.cord_last = 1'b1;
          if (job_r == JOB_PITCH) begin
            state_nxt = S_UPD;
          end else begin
            job_nxt   = job_r + 2'd1;
            state_nxt = S_CLOAD;
          end
        end else begin
          scnt_nxt = scnt_r + SC_W'(1);
        end
      end
      S_UPD: begin
        if (!sts.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mcnt_r  <= '0;
      scnt_r  <= '0;
      job_r   <= JOB_ROLL;
    end else begin
      state_r <= state_nxt;
      mcnt_r  <= mcnt_nxt;
      scnt_r  <= scnt_nxt;
      job_r   <= job_nxt;
    end
  end

  // A non-sample word goes straight to the update step.
  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_fire && in_tuser != CMD_SAMPLE) |=> state_r == S_UPD)
    else $error("non-sample word did not go to update");

  // The pitch job never starts before the square root has settled.
  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOAD && job_r == JOB_PITCH && sts.sqrt_busy) |=> state_r == S_CLOAD)
    else $error("pitch CORDIC loaded while square root busy");

  // Only the three angle jobs exist.
  a_job_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRUN) |-> (job_r == JOB_ROLL || job_r == JOB_YAW || job_r == JOB_PITCH))
    else $error("CORDIC job out of range");

endmodule

// File: sv/qeyt_dp.sv
// ----------------------------------------------------------------------------
// qeyt_dp
// Datapath: shared multiplier, square root, CORDIC, tracker state, output.
// ----------------------------------------------------------------------------
module qeyt_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qeyt_pkg::cmd_t        cmd,
  output qeyt_pkg::sts_t        sts,
  input  logic [1:0]            in_tuser,
  input  logic [111:0]          in_tdata,
  input  logic                  cfg_valid,
  input  logic [0:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [151:0]          out_tdata
);
  import qeyt_pkg::*;

  // Captured input word.
  logic [1:0]         op_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic [47:0]        now_r;

  // Configuration.
  logic        hall_en_r;
  logic [31:0] timeout_r;

  // Product accumulators.
  logic signed [31:0] prod_r;
  logic [3:0]         pidx_r;
  logic               pval_r;
  logic signed [33:0] acc_sr_r, acc_rr_r, acc_sp_r, acc_sy_r, acc_cy_r;
  logic signed [15:0] ma, mb;

  // Square root.
  logic [56:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [57:0] sq_t;

  // CORDIC.
  logic signed [CXY_W-1:0] cx_r, cy_r, cx_nxt, cy_nxt, x_in, y_in, dx, dy;
  logic signed [CZ_W-1:0]  cz_r, cz_nxt, z_round;
  logic                    czero_r;
  logic signed [15:0]      ang;

  // Angles and tracker state.
  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic signed [15:0] prev_yaw_r, zero_off_r, latest_yaw_r;
  logic [31:0]        unwrap_r, samples_r;
  logic               started_r, flagged_r;
  logic [47:0]        last_pulse_r;
  logic [15:0]        timeouts_r;
  logic               out_valid_r;
  logic [151:0]       out_data_r;

  // Derived sums.
  logic signed [34:0] sr, cr, sp, sy, cy;
  logic               sp_hi, sp_lo;
  logic signed [28:0] sp29;
  logic signed [57:0] sp_sq;
  logic [56:0]        sq_init;
  logic signed [17:0] ydiff;
  logic [47:0]        elapsed;
  logic signed [15:0] yzero;

  assign sr = {acc_sr_r, 1'b0};
  assign cr = 35'sd268435456 - {acc_rr_r, 1'b0};
  assign sp = {acc_sp_r, 1'b0};
  assign sy = {acc_sy_r, 1'b0};
  assign cy = 35'sd268435456 - {acc_cy_r, 1'b0};
  assign sp_hi = (sp >= 35'sd268435456);
  assign sp_lo = (sp <= -35'sd268435456);
  assign sp29  = sp[28:0];
  assign sp_sq = sp29 * sp29;
  assign sq_init = 57'h100000000000000 - sp_sq[56:0];

  assign sts.sqrt_busy = (sq_bit_r != '0);
  assign sts.out_busy  = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  // Input capture and configuration writes.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_tuser;
      qw_r  <= in_tdata[15:0];
      qx_r  <= in_tdata[31:16];
      qy_r  <= in_tdata[47:32];
      qz_r  <= in_tdata[63:48];
      now_r <= in_tdata[111:64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hall_en_r <= 1'b0;
      timeout_r <= 32'd1000000;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HALL_ENABLED) hall_en_r <= cfg_data[0];
      if (cfg_index == REG_HALL_TIMEOUT) timeout_r <= cfg_data;
    end
  end

  // Operand pairs of the product pass.
  always_comb begin
    case (cmd.mul_idx)
      4'd0:    begin ma = qw_r; mb = qx_r; end
      4'd1:    begin ma = qy_r; mb = qz_r; end
      4'd2:    begin ma = qx_r; mb = qx_r; end
      4'd3:    begin ma = qy_r; mb = qy_r; end
      4'd4:    begin ma = qw_r; mb = qy_r; end
      4'd5:    begin ma = qz_r; mb = qx_r; end
      4'd6:    begin ma = qw_r; mb = qz_r; end
      4'd7:    begin ma = qx_r; mb = qy_r; end
      4'd8:    begin ma = qy_r; mb = qy_r; end
      4'd9:    begin ma = qz_r; mb = qz_r; end
      default: begin ma = '0;   mb = '0;   end
    endcase
  end

  // Multiply into a register, then accumulate the registered product in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pval_r <= 1'b0;
    end else begin
      pval_r <= cmd.mul_en;
    end
    prod_r <= ma * mb;
    pidx_r <= cmd.mul_idx;
    if (cmd.mul_clear) begin
      acc_sr_r <= '0;
      acc_rr_r <= '0;
      acc_sp_r <= '0;
      acc_sy_r <= '0;
      acc_cy_r <= '0;
    end else if (pval_r) begin
      case (pidx_r)
        4'd0, 4'd1: acc_sr_r <= acc_sr_r + 34'(prod_r);
        4'd2, 4'd3: acc_rr_r <= acc_rr_r + 34'(prod_r);
        4'd4:       acc_sp_r <= acc_sp_r + 34'(prod_r);
        4'd5:       acc_sp_r <= acc_sp_r - 34'(prod_r);
        4'd6, 4'd7: acc_sy_r <= acc_sy_r + 34'(prod_r);
        4'd8, 4'd9: acc_cy_r <= acc_cy_r + 34'(prod_r);
        default: ;
      endcase
    end
  end

  // Bit-pair integer square root, one result bit per cycle.
  assign sq_t = {1'b0, sq_res_r} + {1'b0, sq_bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else if (cmd.sqrt_start) begin
      sq_n_r   <= sq_init;
      sq_res_r <= '0;
      sq_bit_r <= 57'h100000000000000;
    end else if (sq_bit_r != '0) begin
      if ({1'b0, sq_n_r} >= sq_t) begin
        sq_n_r   <= sq_n_r - sq_t[56:0];
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // CORDIC operand selection for the current job.
  always_comb begin
    case (cmd.job)
      JOB_ROLL: begin x_in = CXY_W'(cr); y_in = CXY_W'(sr); end
      JOB_YAW:  begin x_in = CXY_W'(cy); y_in = CXY_W'(sy); end
      default:  begin
        x_in = CXY_W'($signed({1'b0, sq_res_r[28:0]}));
        y_in = CXY_W'(sp);
      end
    endcase
  end

  // One vectoring rotation.
  always_comb begin
    dx = cy_r >>> cmd.step_idx;
    dy = cx_r >>> cmd.step_idx;
    if (cy_r >= 0) begin
      cx_nxt = cx_r + dx;
      cy_nxt = cy_r - dy;
      cz_nxt = cz_r + CZ_W'(atan_of(cmd.step_idx));
    end else begin
      cx_nxt = cx_r - dx;
      cy_nxt = cy_r + dy;
      cz_nxt = cz_r - CZ_W'(atan_of(cmd.step_idx));
    end
    z_round = cz_nxt + CZ_W'(32768);
    ang = czero_r ? 16'sd0 : z_round[31:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.cord_load) begin
      czero_r <= (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
        cz_r <= (y_in >= 0) ? CZ_W'(64'sd2147483648) : CZ_W'(-64'sd2147483648);
        cx_r <= -x_in;
        cy_r <= -y_in;
      end else begin
        cz_r <= '0;
        cx_r <= x_in;
        cy_r <= y_in;
      end
    end else if (cmd.cord_step) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
    // Store the finished angle of the job.
    if (cmd.cord_step && cmd.cord_last) begin
      case (cmd.job)
        JOB_ROLL: roll_r <= ang;
        JOB_YAW:  yaw_r  <= ang;
        default: begin
          if (sp_hi || ang > 16'sd16384)       pitch_r <= 16'sd16384;
          else if (sp_lo || ang < -16'sd16384) pitch_r <= -16'sd16384;
          else                                 pitch_r <= ang;
        end
      endcase
    end
  end

  // Wrapped yaw change and hall silence.
  always_comb begin
    ydiff = 18'(yaw_r) - 18'(prev_yaw_r);
    if (ydiff > 18'sd32768)       ydiff = ydiff - 18'sd65536;
    else if (ydiff < -18'sd32768) ydiff = ydiff + 18'sd65536;
    elapsed = now_r - last_pulse_r;
    yzero   = latest_yaw_r - zero_off_r;
  end

  // Tracker state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_yaw_r   <= '0;
      unwrap_r     <= '0;
      started_r    <= 1'b0;
      zero_off_r   <= '0;
      latest_yaw_r <= '0;
      last_pulse_r <= '0;
      flagged_r    <= 1'b0;
      timeouts_r   <= '0;
      samples_r    <= '0;
    end else if (cmd.update) begin
      case (op_r)
        CMD_SAMPLE: begin
          if (!started_r) begin
            unwrap_r  <= '0;
            started_r <= 1'b1;
          end else begin
            unwrap_r <= unwrap_r + 32'($signed(ydiff));
          end
          prev_yaw_r   <= yaw_r;
          latest_yaw_r <= yaw_r;
          samples_r    <= samples_r + 32'd1;
        end
        CMD_HALL: begin
          if (hall_en_r) begin
            last_pulse_r <= now_r;
            zero_off_r   <= latest_yaw_r;
            unwrap_r     <= '0;
            flagged_r    <= 1'b0;
          end
        end
        CMD_CHECK: begin
          if (hall_en_r && last_pulse_r != '0 && !flagged_r && now_r >= last_pulse_r &&
              elapsed > {16'd0, timeout_r}) begin
            if (timeouts_r != 16'hFFFF) timeouts_r <= timeouts_r + 16'd1;
            flagged_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register, filled in the cycle after the update from the new state.
  logic upd_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_d_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upd_d_r <= cmd.update;
      if (upd_d_r)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    if (upd_d_r) begin
      out_data_r <= {7'd0, flagged_r, timeouts_r, samples_r, unwrap_r, yzero, latest_yaw_r,
                     (op_r == CMD_SAMPLE) ? pitch_r : 16'sd0,
                     (op_r == CMD_SAMPLE) ? roll_r : 16'sd0};
    end
  end

endmodule

// File: dv/tb_quaternion_euler_yaw_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_euler_yaw_tracker_core
// Self-checking bench: drives samples, hall pulses and time checks, predicts
// every result word in a local tracker model and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_euler_yaw_tracker_core;
  import qeyt_pkg::*;

  // Expected contents of one result word.
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] yaw_zeroed;
    logic [31:0]        yaw_cont;
    logic [31:0]        samples;
    logic [15:0]        timeouts;
    logic               tmo_active;
  } attitude_t;

  // Tracker model and queue of predicted attitude words.
  class attitude_tracker;
    bit          hall_en;
    bit [31:0]   hall_tmo;
    logic signed [15:0] prev_yaw, zero_ofs, last_yaw;
    bit [31:0]   unwrapped;
    bit          started;
    bit [47:0]   pulse_time;
    bit          flagged;
    bit [15:0]   timeouts;
    bit [31:0]   samples;
    int          steps;
    attitude_t   pending[$];
    int          errors;
    int          checked;

    function new(int cordic_steps);
      steps = cordic_steps;
      hall_en = 0; hall_tmo = 32'd1000000;
      prev_yaw = 0; zero_ofs = 0; last_yaw = 0;
      unwrapped = 0; started = 0; pulse_time = 0; flagged = 0;
      timeouts = 0; samples = 0; errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == REG_HALL_ENABLED) hall_en = val[0];
      else hall_tmo = val;
    endfunction

    // Vectoring CORDIC angle, rounded to 65536 per turn.
    function logic signed [15:0] cordic_angle(longint x, longint y);
      longint z, dx, dy;
      int n;
      logic [63:0] r;
      if (x == 0 && y == 0) return 16'sd0;
      n = (steps > 24) ? 24 : steps;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
        x = -x; y = -y;
      end
      for (int i = 0; i < n; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(atan_of(i[4:0]));
        end else begin
          x -= dx; y += dy; z -= longint'(atan_of(i[4:0]));
        end
      end
      r = (z + 32768) >>> 16;
      return r[15:0];
    endfunction

    function longint floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b; res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return longint'(res);
    endfunction

    // Notes one accepted input word and queues its expected result.
    function void note_input(logic [1:0] cmd, logic [111:0] d);
      longint w, x, y, z, sr, cr, sp, sy, cy, one;
      logic signed [15:0] yaw;
      int dlt;
      attitude_t e;
      logic [47:0] now;
      w = longint'($signed(d[15:0])); x = longint'($signed(d[31:16]));
      y = longint'($signed(d[47:32])); z = longint'($signed(d[63:48]));
      now = d[111:64];
      e = '0;
      one = 64'sd1 <<< 28;
      if (cmd == CMD_SAMPLE) begin
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        e.roll = cordic_angle(cr, sr);
        if (sp >= one) e.pitch = 16'sd16384;
        else if (sp <= -one) e.pitch = -16'sd16384;
        else begin
          e.pitch = cordic_angle(floor_sqrt((64'd1 << 56) - longint'(sp * sp)), sp);
          if (e.pitch > 16'sd16384) e.pitch = 16'sd16384;
          if (e.pitch < -16'sd16384) e.pitch = -16'sd16384;
        end
        yaw = cordic_angle(cy, sy);
        if (!started) begin
          prev_yaw = yaw; unwrapped = 0; started = 1;
        end else begin
          dlt = int'(yaw) - int'(prev_yaw);
          if (dlt > 32768) dlt -= 65536;
          else if (dlt < -32768) dlt += 65536;
          unwrapped += dlt;
          prev_yaw = yaw;
        end
        samples++;
        last_yaw = yaw;
      end else if (cmd == CMD_HALL) begin
        if (hall_en) begin
          pulse_time = now; zero_ofs = last_yaw; unwrapped = 0; flagged = 0;
        end
      end else if (cmd == CMD_CHECK) begin
        if (hall_en && pulse_time != 0 && !flagged && now >= pulse_time &&
            (now - pulse_time) > {16'd0, hall_tmo}) begin
          if (timeouts != 16'hFFFF) timeouts++;
          flagged = 1;
        end
      end
      e.yaw_raw = last_yaw;
      e.yaw_zeroed = last_yaw - zero_ofs;
      e.yaw_cont = unwrapped;
      e.samples = samples;
      e.timeouts = timeouts;
      e.tmo_active = flagged;
      pending.push_back(e);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= 40)
        $display("MISMATCH %s: expected %0h got %0h (word %0d)", what, exp_v, got_v,
                 checked);
    endfunction

    // Checks one result word against the oldest expectation.
    function void check_result(logic [151:0] d);
      attitude_t e;
      if (pending.size() == 0) begin
        report("unexpected result word", 0, d[31:0]);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[15:0] !== e.roll) report("roll_angle", e.roll, d[15:0]);
      if (d[31:16] !== e.pitch) report("pitch_angle", e.pitch, d[31:16]);
      if (d[47:32] !== e.yaw_raw) report("yaw_raw", e.yaw_raw, d[47:32]);
      if (d[63:48] !== e.yaw_zeroed) report("yaw_zeroed", e.yaw_zeroed, d[63:48]);
      if (d[95:64] !== e.yaw_cont) report("yaw_continuous", e.yaw_cont, d[95:64]);
      if (d[127:96] !== e.samples) report("sample_count", e.samples, d[127:96]);
      if (d[143:128] !== e.timeouts) report("timeout_count", e.timeouts, d[143:128]);
      if (d[144] !== e.tmo_active) report("timeout_active", e.tmo_active, d[144]);
    endfunction
  endclass

  localparam int STEPS = 16;
  localparam int WATCHDOG = 20000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = CMD_SAMPLE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = REG_HALL_ENABLED;
  logic [31:0]  cfg_data = '0;

  attitude_tracker model = new(STEPS);
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  idle_cycles = 0;
  int  words_sent = 0;
  int  cmd_seen[4];
  logic [47:0] clock_us = 48'd1000;

  quaternion_euler_yaw_tracker_core #(.CORDIC_STEPS(STEPS)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall and checking.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d words pending", model.pending.size());
      $display("tb_quaternion_euler_yaw_tracker_core: errors");
      $finish;
    end
  end

  // Valid stays high after a word is taken so that words can follow back to back;
  // an idle gap or a drain drops it.
  task automatic send_word(logic [1:0] cmd, logic [15:0] w, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z, logic [47:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {t, z, y, x, w};
    do @(posedge clk); while (!in_tready);
    model.note_input(cmd, {t, z, y, x, w});
    cmd_seen[cmd]++;
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (4 * STEPS + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unit quaternion-ish random values, mostly within Q1.14 range.
  function automatic logic [15:0] rand_comp();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 16'($signed($urandom_range(32768)) - 16384);
    if (r < 90) return 16'($urandom_range(65535));
    return (r < 95) ? 16'h4000 : 16'hC000;
  endfunction

  task automatic rand_word();
    int r;
    r = $urandom_range(99);
    clock_us += 48'($urandom_range(3000));
    if (r < 60) send_word(CMD_SAMPLE, rand_comp(), rand_comp(), rand_comp(),
                          rand_comp(), 48'($urandom()));
    else if (r < 72) send_word(CMD_HALL, rand_comp(), rand_comp(), rand_comp(),
                               rand_comp(), ($urandom_range(19) == 0) ? 48'd0 : clock_us);
    else if (r < 96) begin
      if ($urandom_range(9) == 0) clock_us = clock_us - 48'($urandom_range(5000));
      send_word(CMD_CHECK, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()),
                ($urandom_range(29) == 0) ? {$urandom(), 16'($urandom())} : clock_us);
    end else send_word(2'd3, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), {$urandom(), 16'($urandom())});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, special cases, every command, register settings.
    write_reg(REG_HALL_ENABLED, 32'd1);
    write_reg(REG_HALL_TIMEOUT, 32'd1);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'd500);
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0);
    send_word(CMD_SAMPLE, 16'h4000, 16'h0000, 16'h0000, 16'h0000, '0);
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h4000, '0);
    send_word(CMD_SAMPLE, 16'h2D41, 16'h0000, 16'h2D41, 16'h0000, '0);
    send_word(CMD_SAMPLE, 16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, '0);
    send_word(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 48'hFFFF_FFFF_FFFF);
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '0);
    send_word(CMD_SAMPLE, 16'h2D41, 16'h0000, 16'h0000, 16'hD2BF, '0);
    send_word(CMD_SAMPLE, 16'h2D41, 16'h0000, 16'h0000, 16'h2D41, '0);
    send_word(CMD_HALL, '0, '0, '0, '0, 48'd0);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'd100);
    send_word(CMD_HALL, '0, '0, '0, '0, 48'd1000);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'd999);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'd1001);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'd1002);
    send_word(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    wait_drained();
    write_reg(REG_HALL_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_HALL_ENABLED, 32'd0);
    send_word(CMD_HALL, '0, '0, '0, '0, 48'd5);
    send_word(CMD_CHECK, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    wait_drained();

    // Random phases with differing idle patterns and register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      write_reg(REG_HALL_ENABLED, (ph == 5) ? 32'd0 : 32'd1);
      write_reg(REG_HALL_TIMEOUT, (ph == 7) ? 32'hFFFF_FFFF :
                                  (ph == 3) ? 32'd1 : $urandom_range(4000, 1));
      for (int k = 0; k < 135; k++) begin
        rand_word();
        if (k == 60) wait_drained();
      end
      wait_drained();
    end

    $display("sent %0d words: %0d samples, %0d pulses, %0d checks, %0d other",
             words_sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("checked %0d results across 8 idle and register phases", model.checked);
    if (model.errors == 0 && model.pending.size() == 0)
      $display("tb_quaternion_euler_yaw_tracker_core: clean");
    else
      $display("tb_quaternion_euler_yaw_tracker_core: errors");
    $finish;
  end
endmodule

// File: filelist.f
sv/qeyt_pkg.sv
sv/qeyt_ctrl.sv
sv/qeyt_dp.sv
sv/quaternion_euler_yaw_tracker_core.sv
dv/tb_quaternion_euler_yaw_tracker_core.sv
